// ----- hw/rtl/pfrc_pkg.sv -----
// Shared types and constants of the page frame reference counter.
package pfrc_pkg;

  localparam int unsigned FRAME_SHIFT = 12;
  localparam logic [31:0] PAGE_MASK   = 32'hffff_f000;
  localparam logic [31:0] WRITABLE    = 32'h0000_0002;
  localparam logic [31:0] NEW_FLAGS   = 32'h0000_0007;

  // Input operation codes.
  localparam logic [2:0] MODE_INIT   = 3'd0;
  localparam logic [2:0] MODE_FREE   = 3'd1;
  localparam logic [2:0] MODE_SHARE  = 3'd2;
  localparam logic [2:0] MODE_FAULT  = 3'd3;
  localparam logic [2:0] MODE_VERIFY = 3'd4;

  // Result status codes.
  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_IGNORED  = 3'd1;
  localparam logic [2:0] ST_NONEXIST = 3'd2;
  localparam logic [2:0] ST_FREE     = 3'd3;
  localparam logic [2:0] ST_SAT      = 3'd4;

  // Configuration register indexes.
  localparam logic REG_LOW_MEMORY = 1'b0;
  localparam logic REG_MEM_END    = 1'b1;

  localparam logic [7:0] COUNT_MAX = 8'd255;

  typedef enum logic [2:0] {
    OP_IGNORE,
    OP_INIT,
    OP_FREE,
    OP_SHARE,
    OP_FAULT
  } op_t;

  typedef enum logic [1:0] {
    LOC_BELOW,
    LOC_COUNTED,
    LOC_ABSENT
  } loc_t;

  typedef struct packed {
    op_t  op;
    loc_t loc;
  } decode_t;

  typedef struct packed {
    logic [7:0]  count_after;
    logic [2:0]  status;
    logic        need_copy;
    logic [31:0] new_entry;
  } result_t;

endpackage

// ----- hw/rtl/pfrc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module pfrc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/pfrc_front.sv -----
// Operation decode and frame lookup for an incoming beat.
module pfrc_front #(
  parameter int unsigned FRAME_COUNT = 4096
) (
  input  logic [2:0]                     mode,
  input  logic [31:0]                    entry_word,
  input  logic [31:0]                    low_memory,
  input  logic [31:0]                    mem_end,
  output pfrc_pkg::decode_t              dec,
  output logic [$clog2(FRAME_COUNT)-1:0] idx
);
  import pfrc_pkg::*;

  localparam int unsigned IDX_W = $clog2(FRAME_COUNT);

  logic [31:0] addr;
  logic [31:0] diff;
  logic        beyond;

  always_comb begin
    // Init and free take a plain frame address, the rest take an entry.
    if (mode == MODE_INIT || mode == MODE_FREE) begin
      addr = entry_word;
    end else begin
      addr = entry_word & PAGE_MASK;
    end
    diff   = addr - low_memory;
    beyond = (addr >= mem_end) ||
             ({1'b0, diff[31:FRAME_SHIFT]} >= 21'(FRAME_COUNT));
    idx    = diff[FRAME_SHIFT +: IDX_W];

    if (addr < low_memory) begin
      dec.loc = LOC_BELOW;
    end else if (beyond) begin
      dec.loc = LOC_ABSENT;
    end else begin
      dec.loc = LOC_COUNTED;
    end

    unique case (mode)
      MODE_INIT:   dec.op = OP_INIT;
      MODE_FREE:   dec.op = OP_FREE;
      MODE_SHARE:  dec.op = entry_word[0] ? OP_SHARE : OP_IGNORE;
      MODE_FAULT:  dec.op = OP_FAULT;
      MODE_VERIFY: dec.op = (entry_word[1:0] == 2'b01) ? OP_FAULT : OP_IGNORE;
      default:     dec.op = OP_IGNORE;
    endcase
  end

endmodule

// ----- hw/rtl/pfrc_update.sv -----
// Count modify step: new count, write-back decision and result fields.
module pfrc_update (
  input  pfrc_pkg::decode_t dec,
  input  logic [31:0]       entry_word,
  input  logic [31:0]       new_frame,
  input  logic [7:0]        cnt,
  output logic              wr_en,
  output logic [7:0]        wr_cnt,
  output pfrc_pkg::result_t res
);
  import pfrc_pkg::*;

  logic counted;
  logic cnt_zero;

  always_comb begin
    counted  = (dec.loc == LOC_COUNTED);
    cnt_zero = (cnt == 8'd0);

    wr_en           = 1'b0;
    wr_cnt          = cnt - 8'd1;
    res.new_entry   = entry_word;
    res.need_copy   = 1'b0;
    res.status      = ST_DONE;
    res.count_after = 8'd0;

    unique case (dec.op)
      OP_INIT: begin
        wr_cnt = 8'd0;
        if (dec.loc == LOC_BELOW) begin
          res.status = ST_IGNORED;
        end else if (dec.loc == LOC_ABSENT) begin
          res.status = ST_NONEXIST;
        end else begin
          wr_en = 1'b1;
        end
      end
      OP_FREE: begin
        if (dec.loc == LOC_BELOW) begin
          res.status = ST_IGNORED;
        end else if (dec.loc == LOC_ABSENT) begin
          res.status = ST_NONEXIST;
        end else if (cnt_zero) begin
          res.status = ST_FREE;
        end else begin
          wr_en           = 1'b1;
          res.count_after = wr_cnt;
        end
      end
      OP_SHARE: begin
        wr_cnt        = cnt + 8'd1;
        res.new_entry = entry_word & ~WRITABLE;
        if (dec.loc == LOC_ABSENT) begin
          res.status = ST_NONEXIST;
        end else if (counted) begin
          if (cnt == COUNT_MAX) begin
            res.status      = ST_SAT;
            res.count_after = COUNT_MAX;
          end else begin
            wr_en           = 1'b1;
            res.count_after = wr_cnt;
          end
        end
      end
      OP_FAULT: begin
        if (counted && cnt == 8'd1) begin
          // Sole owner: just make the mapping writable again.
          res.new_entry   = entry_word | WRITABLE;
          res.count_after = 8'd1;
        end else begin
          res.new_entry = new_frame | NEW_FLAGS;
          res.need_copy = 1'b1;
          if (dec.loc == LOC_ABSENT) begin
            res.status = ST_NONEXIST;
          end else if (counted) begin
            if (cnt_zero) begin
              res.status = ST_FREE;
            end else begin
              wr_en           = 1'b1;
              res.count_after = wr_cnt;
            end
          end
        end
      end
      default: begin
        res.status = ST_IGNORED;
      end
    endcase
  end

endmodule

// ----- hw/rtl/page_frame_refcount_cow.sv -----
// Top level of the page frame reference counter with copy-on-write support.
//
//   channel  direction  signals                        content
//   s_*      in         s_tvalid s_tready s_tdata[71]  mode, entry_word, new_frame
//   m_*      out        m_tvalid m_tready m_tdata[47]  new_entry, need_copy, status,
//                                                      count_after
//   cfg_*    in         cfg_we cfg_index cfg_data[31]  low_memory, mem_end
//
// One beat per cycle sustained while the output is not stalled; a beat passes the
// count stage and then the result register. The rate is set by the single count
// RAM: one read at accept and one write-back as the beat leaves the count stage,
// with the write of the beat ahead forwarded to the next beat. After reset a
// clearing pass writes USED_MARK to all FRAME_COUNT entries, one a cycle, and
// s_tready stays low until the pass ends. A stalled output holds the result
// register; once the count stage also holds a beat, the input waits.
module page_frame_refcount_cow #(
  parameter int unsigned FRAME_COUNT = 4096,
  parameter int unsigned USED_MARK   = 100
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // mode[2:0], entry_word[34:3], new_frame[66:35]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // new_entry[31:0], need_copy[32], status[35:33],
                                 // count_after[43:36]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import pfrc_pkg::*;

  localparam int unsigned IDX_W = $clog2(FRAME_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_COUNT - 1);

  logic [31:0] low_memory;
  logic [31:0] mem_end;

  logic             clearing;
  logic [IDX_W-1:0] clr_idx;

  decode_t          front_dec;
  logic [IDX_W-1:0] front_idx;

  logic             s1_valid;
  decode_t          s1_dec;
  logic [IDX_W-1:0] s1_idx;
  logic [31:0]      s1_entry;
  logic [31:0]      s1_fresh;
  logic             fwd_hit;
  logic [7:0]       fwd_cnt;

  logic             out_valid;
  result_t          out_res;

  logic             accept;
  logic             s1_advance;
  logic             s1_write;
  logic [7:0]       ram_rdata;
  logic [7:0]       cur_cnt;
  logic             upd_wr_en;
  logic [7:0]       upd_wr_cnt;
  result_t          upd_res;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [7:0]       ram_wdata;

  pfrc_front #(.FRAME_COUNT(FRAME_COUNT)) u_front (
    .mode        (s_tdata[2:0]),
    .entry_word  (s_tdata[34:3]),
    .low_memory  (low_memory),
    .mem_end     (mem_end),
    .dec         (front_dec),
    .idx         (front_idx)
  );

  assign s1_advance = !out_valid || m_tready;
  assign s_tready   = !clearing && (!s1_valid || s1_advance);
  assign accept     = s_tvalid && s_tready;
  assign cur_cnt    = fwd_hit ? fwd_cnt : ram_rdata;
  assign s1_write   = s1_valid && s1_advance && upd_wr_en;

  pfrc_update u_update (
    .dec        (s1_dec),
    .entry_word (s1_entry),
    .new_frame  (s1_fresh),
    .cnt        (cur_cnt),
    .wr_en      (upd_wr_en),
    .wr_cnt     (upd_wr_cnt),
    .res        (upd_res)
  );

  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx;
      ram_wdata = 8'(USED_MARK);
    end else begin
      ram_we    = s1_write;
      ram_waddr = s1_idx;
      ram_wdata = upd_wr_cnt;
    end
  end

  pfrc_ram #(.WIDTH(8), .DEPTH(FRAME_COUNT)) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (front_idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      low_memory  <= 32'h0010_0000;
      mem_end     <= 32'h0100_0000;
      clearing    <= 1'b1;
      clr_idx     <= '0;
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      fwd_hit     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LOW_MEMORY: low_memory <= cfg_data;
          REG_MEM_END:    mem_end    <= cfg_data;
          default: ;
        endcase
      end

      if (clearing) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == LAST_IDX) begin
          clearing <= 1'b0;
        end
      end

      if (accept) begin
        s1_valid <= 1'b1;
        s1_dec   <= front_dec;
        s1_idx   <= front_idx;
        s1_entry <= s_tdata[34:3];
        s1_fresh <= s_tdata[66:35];
        // The RAM read at this edge misses a write-back landing at the same edge.
        fwd_hit  <= s1_write && (s1_idx == front_idx);
        fwd_cnt  <= upd_wr_cnt;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end

      if (s1_valid && s1_advance) begin
        out_valid <= 1'b1;
        out_res   <= upd_res;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_res};

endmodule

// ----- hw/rtl/pfrc_checker.sv -----
// Port-level checks of the page frame reference counter, bound to the top level.
module pfrc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);
  import pfrc_pkg::*;

  // A result beat that is not taken stays put.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // The clearing pass keeps the input closed right after reset.
  assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input ready during clearing pass");

  // A copy request always carries the fresh frame with all flags set.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[32] |-> m_tdata[2:0] == 3'b111 && m_tdata[35:33] != ST_SAT &&
      m_tdata[35:33] != ST_IGNORED)
    else $error("copy request with bad entry or status");

  // Saturation reports the top count, and the pad bits stay zero.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[35:33] == ST_SAT |-> m_tdata[43:36] == COUNT_MAX &&
      m_tdata[47:44] == 4'b0000)
    else $error("saturated result with wrong count");

endmodule

bind page_frame_refcount_cow pfrc_checker u_pfrc_checker (.*);

// ----- dv/page_frame_refcount_cow_tb.sv -----
// Self-checking testbench of the page frame reference counter with copy-on-write.
`timescale 1ns / 100ps

module page_frame_refcount_cow_tb;
  import pfrc_pkg::*;

  localparam int unsigned FRAMES      = 4096;
  localparam int unsigned USED        = 100;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata   = '0;   // mode[2:0], entry_word[34:3], new_frame[66:35]
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [47:0] m_tdata;          // new_entry[31:0], need_copy[32], status[35:33],
                                 // count_after[43:36]
  logic        cfg_we    = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data  = '0;

  int unsigned send_gap_pct = 0;
  int unsigned stall_pct    = 0;
  int unsigned cycle_count  = 0;
  int unsigned pool [6];
  int unsigned pool_frames;

  page_frame_refcount_cow #(
    .FRAME_COUNT(FRAMES),
    .USED_MARK  (USED)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Tracks the per-frame counts and the memory window, and holds the results
  // that accepted operations are due to produce.
  class frame_ref_board;
    logic [7:0]  counts [FRAMES];
    logic [31:0] low_mem;
    logic [31:0] high_mem;
    result_t     due_results [$];
    int unsigned errors;

    function new();
      foreach (counts[i]) counts[i] = 8'(USED);
      low_mem  = 32'h0010_0000;
      high_mem = 32'h0100_0000;
      errors   = 0;
    endfunction

    function void set_limits(logic [31:0] low, logic [31:0] high);
      low_mem  = low;
      high_mem = high;
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    function loc_t locate(input logic [31:0] addr, output int unsigned idx);
      logic [31:0] frame;
      idx = 0;
      if (addr < low_mem) return LOC_BELOW;
      if (addr >= high_mem) return LOC_ABSENT;
      frame = (addr - low_mem) >> FRAME_SHIFT;
      if (frame >= FRAMES) return LOC_ABSENT;
      idx = frame;
      return LOC_COUNTED;
    endfunction

    function result_t resolve_fault(logic [31:0] entry, logic [31:0] fresh, result_t r);
      int unsigned idx;
      loc_t        where;
      where = locate(entry & PAGE_MASK, idx);
      // A sole owner simply gets its write permission back.
      if (where == LOC_COUNTED && counts[idx] == 8'd1) begin
        r.new_entry   = entry | WRITABLE;
        r.count_after = 8'd1;
        return r;
      end
      r.new_entry = fresh | NEW_FLAGS;
      r.need_copy = 1'b1;
      if (where == LOC_COUNTED) begin
        if (counts[idx] == 8'd0) r.status = ST_FREE;
        else counts[idx] = counts[idx] - 8'd1;
        r.count_after = counts[idx];
      end else if (where == LOC_ABSENT) begin
        r.status = ST_NONEXIST;
      end
      return r;
    endfunction

    function void note_input(logic [2:0] mode, logic [31:0] entry, logic [31:0] fresh);
      result_t     r;
      int unsigned idx;
      loc_t        where;
      r.new_entry   = entry;
      r.need_copy   = 1'b0;
      r.status      = ST_DONE;
      r.count_after = 8'd0;
      case (mode)
        MODE_INIT: begin
          where = locate(entry, idx);
          if (where == LOC_BELOW) r.status = ST_IGNORED;
          else if (where == LOC_ABSENT) r.status = ST_NONEXIST;
          else counts[idx] = 8'd0;
        end
        MODE_FREE: begin
          where = locate(entry, idx);
          if (where == LOC_BELOW) r.status = ST_IGNORED;
          else if (where == LOC_ABSENT) r.status = ST_NONEXIST;
          else begin
            if (counts[idx] == 8'd0) r.status = ST_FREE;
            else counts[idx] = counts[idx] - 8'd1;
            r.count_after = counts[idx];
          end
        end
        MODE_SHARE: begin
          if (!entry[0]) r.status = ST_IGNORED;
          else begin
            r.new_entry = entry & ~WRITABLE;
            where = locate(entry & PAGE_MASK, idx);
            if (where == LOC_ABSENT) r.status = ST_NONEXIST;
            else if (where == LOC_COUNTED) begin
              if (counts[idx] == COUNT_MAX) r.status = ST_SAT;
              else counts[idx] = counts[idx] + 8'd1;
              r.count_after = counts[idx];
            end
          end
        end
        MODE_FAULT: r = resolve_fault(entry, fresh, r);
        MODE_VERIFY: begin
          if (entry[1:0] == 2'b01) r = resolve_fault(entry, fresh, r);
          else r.status = ST_IGNORED;
        end
        default: r.status = ST_IGNORED;
      endcase
      due_results.push_back(r);
    endfunction

    function void check_result(logic [47:0] data);
      result_t got;
      result_t want;
      got = result_t'(data[43:0]);
      if (due_results.size() == 0) begin
        $display("%0t: result beat %h arrived with nothing expected", $time, data);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (got.new_entry !== want.new_entry) begin
        $display("%0t: new_entry expected %h, got %h", $time, want.new_entry, got.new_entry);
        errors++;
      end
      if (got.need_copy !== want.need_copy) begin
        $display("%0t: need_copy expected %b, got %b", $time, want.need_copy, got.need_copy);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.count_after !== want.count_after) begin
        $display("%0t: count_after expected %0d, got %0d", $time, want.count_after,
                 got.count_after);
        errors++;
      end
    endfunction
  endclass

  frame_ref_board board = new();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[page_frame_refcount_cow] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) board.check_result(m_tdata);
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_op(input logic [2:0] mode, input logic [31:0] entry,
                         input logic [31:0] fresh);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, fresh, entry, mode};
    do @(posedge clk); while (!s_tready);
    board.note_input(mode, entry, fresh);
  endtask

  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limits(input logic [31:0] low, input logic [31:0] high);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LOW_MEMORY;
    cfg_data  <= low;
    @(posedge clk);
    cfg_index <= REG_MEM_END;
    cfg_data  <= high;
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.set_limits(low, high);
  endtask

  // A few frames of the counted window are reused so that counts walk through
  // zero, one and back; the first and last frame of the window are always in it.
  function automatic void build_pool();
    logic [31:0] span;
    span = (board.high_mem > board.low_mem) ? board.high_mem - board.low_mem : 32'd0;
    pool_frames = (span == 0) ? 0 : ((span - 1) >> FRAME_SHIFT) + 1;
    if (pool_frames > FRAMES) pool_frames = FRAMES;
    foreach (pool[i]) pool[i] = (pool_frames == 0) ? 0 : $urandom_range(pool_frames - 1);
    if (pool_frames != 0) begin
      pool[0] = 0;
      pool[1] = pool_frames - 1;
    end
  endfunction

  function automatic logic [31:0] pick_address();
    int unsigned roll;
    roll = $urandom_range(99);
    if (pool_frames != 0 && roll < 75)
      return board.low_mem + pool[$urandom_range(5)] * 4096 + $urandom_range(4095);
    if (roll < 85 && board.low_mem != 0)
      return $urandom_range(board.low_mem - 1);
    if (roll < 93)
      return board.high_mem + $urandom_range(3) * 4096 + $urandom_range(4095);
    return $urandom;
  endfunction

  task automatic random_ops(input int unsigned n);
    int unsigned roll;
    logic [2:0]  mode;
    logic [31:0] addr;
    logic [31:0] flags;
    logic [31:0] entry;
    repeat (n) begin
      roll  = $urandom_range(99);
      addr  = pick_address();
      flags = $urandom_range(4095);
      if (roll < 10) mode = MODE_INIT;
      else if (roll < 25) mode = MODE_FREE;
      else if (roll < 55) mode = MODE_SHARE;
      else if (roll < 72) mode = MODE_FAULT;
      else if (roll < 90) mode = MODE_VERIFY;
      else mode = 3'($urandom_range(7));
      if (mode == MODE_SHARE && $urandom_range(9) != 0) flags[0] = 1'b1;
      if (mode == MODE_VERIFY && $urandom_range(9) < 7) flags[1:0] = 2'b01;
      if (roll >= 95) entry = $urandom;
      else if (mode == MODE_INIT || mode == MODE_FREE) entry = addr;
      else entry = (addr & PAGE_MASK) | flags;
      send_op(mode, entry, $urandom);
    end
  endtask

  // Drives one frame of the default window past the top of its count, then frees it and faults on it.
  task automatic climb_to_saturation(input int unsigned frame_idx, input int unsigned n);
    logic [31:0] base;
    base = board.low_mem + frame_idx * 4096;
    repeat (n) send_op(MODE_SHARE, base | $urandom_range(4095) | 32'd1, $urandom);
    send_op(MODE_FREE, base, $urandom);
    send_op(MODE_FAULT, base | 32'd1, $urandom);
  endtask

  task automatic directed_ops();
    logic [2:0] extra;
    send_op(MODE_INIT,   32'h0010_0000, 32'h0);
    send_op(MODE_FREE,   32'h0010_0000, 32'h0);
    send_op(MODE_SHARE,  32'h0010_0003, 32'h0);
    send_op(MODE_FAULT,  32'h0010_0001, 32'h1234_5000);
    send_op(MODE_SHARE,  32'h0010_0007, 32'h0);
    send_op(MODE_VERIFY, 32'h0010_0FF5, 32'hABCD_E123);
    send_op(MODE_VERIFY, 32'h0010_0003, 32'h5555_5555);
    send_op(MODE_VERIFY, 32'h0010_0000, 32'h5555_5555);
    send_op(MODE_VERIFY, 32'h0010_0002, 32'h5555_5555);
    send_op(MODE_FREE,   32'h0010_0ABC, 32'h0);
    // Copy requested on a frame that is already free.
    send_op(MODE_FAULT,  32'h0010_0001, 32'hFFFF_FFFF);
    send_op(MODE_SHARE,  32'h0010_0002, 32'h0);
    send_op(MODE_INIT,   32'h000F_FFFF, 32'h0);
    send_op(MODE_FREE,   32'h0000_0000, 32'h0);
    send_op(MODE_SHARE,  32'h0000_0003, 32'h0);
    send_op(MODE_FAULT,  32'h0000_0001, 32'h0);
    send_op(MODE_INIT,   32'h0100_0000, 32'h0);
    send_op(MODE_FREE,   32'hFFFF_FFFF, 32'h0);
    send_op(MODE_SHARE,  32'h0100_0003, 32'h0);
    send_op(MODE_FAULT,  32'h0100_0003, 32'hFFFF_F000);
    extra = MODE_VERIFY;
    repeat (3) begin
      extra = extra + 3'd1;
      send_op(extra, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    end
    send_op(MODE_INIT,   32'h00FF_FFFF, 32'h0);
    send_op(MODE_SHARE,  32'h00FF_F001, 32'h0);
    send_op(MODE_FAULT,  32'h00FF_F001, 32'h0);
  endtask

  task automatic run_phase(input logic [31:0] low, input logic [31:0] high,
                           input int unsigned gap, input int unsigned stall,
                           input int unsigned n, input bit hold_midway);
    write_limits(low, high);
    send_gap_pct = gap;
    stall_pct    = stall;
    build_pool();
    if (hold_midway) begin
      random_ops(n / 2);
      wait_for_drain();
      random_ops(n - n / 2);
    end else begin
      random_ops(n);
    end
    wait_for_drain();
  endtask

  initial begin
    logic [31:0] base;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    directed_ops();
    climb_to_saturation(777, 160);
    build_pool();
    random_ops(60);
    wait_for_drain();

    run_phase(32'h0000_0000, 32'hFFFF_FFFF, 49, 0, 130, 1'b0);
    run_phase(32'hFFFF_F000, 32'hFFFF_FFFF, 0, 49, 100, 1'b0);
    base = $urandom_range(32'h100, 32'hF_FF00) << FRAME_SHIFT;
    run_phase(base, base + 48 * 4096 + $urandom_range(4095), 18, 18, 150, 1'b1);
    base = $urandom_range(32'h7FFF_FFFF);
    run_phase(base, base + $urandom_range(4096, 32'h0300_0000), 0, 0, 100, 1'b0);
    run_phase(32'hFFFF_FFFF, 32'h0000_0000, 18, 18, 40, 1'b0);

    repeat (8) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0)
      $display("[page_frame_refcount_cow] OK");
    else
      $display("[page_frame_refcount_cow] ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/pfrc_pkg.sv
hw/rtl/pfrc_ram.sv
hw/rtl/pfrc_front.sv
hw/rtl/pfrc_update.sv
hw/rtl/page_frame_refcount_cow.sv
hw/rtl/pfrc_checker.sv
dv/page_frame_refcount_cow_tb.sv
